### sv/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Types and character constants shared by the string escaper modules.
// ----------------------------------------------------------------------------
package cse_pkg;

    localparam logic       MODE_FULL = 1'b0;
    localparam logic       MODE_MIN  = 1'b1;

    localparam logic [7:0] C_QUOTE   = 8'h22;
    localparam logic [7:0] C_BSLASH  = 8'h5C;
    localparam logic [7:0] C_LF      = 8'h0A;
    localparam logic [7:0] C_CR      = 8'h0D;
    localparam logic [7:0] C_TAB     = 8'h09;
    localparam logic [7:0] C_BEL     = 8'h07;
    localparam logic [7:0] C_ZERO    = 8'h30;
    localparam logic [7:0] C_SEVEN   = 8'h37;
    localparam logic [7:0] C_LOW_N   = 8'h6E;
    localparam logic [7:0] C_LOW_R   = 8'h72;
    localparam logic [7:0] C_LOW_T   = 8'h74;
    localparam logic [7:0] C_LOW_A   = 8'h61;
    localparam logic [7:0] C_PRINT_LO = 8'h20;
    localparam logic [7:0] C_PRINT_HI = 8'h7E;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_PAIR  = 2'd1,
        KIND_OCTAL = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] byte_val;
        logic [7:0] second;
        logic       final_flag;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

### sv/cse_front.sv
// ----------------------------------------------------------------------------
// cse_front
// Holds the escape mode register and classifies each input byte into a
// plain byte, a backslash pair or an octal escape for the queue.
// ----------------------------------------------------------------------------
module cse_front import cse_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_final,
    input  t_q_status  i_q_status,
    output logic       o_in_stall,
    output t_push      o_push
);

    logic  r_mode;
    logic  n_mode;
    t_item w_item;

    always_comb begin
        n_mode = r_mode;
        if (i_cfg_wr_en) begin
            n_mode = i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_FULL;
        end else begin
            r_mode <= n_mode;
        end
    end

    always_comb begin
        w_item.kind       = KIND_PLAIN;
        w_item.byte_val   = i_in_byte;
        w_item.second     = i_in_byte;
        w_item.final_flag = i_in_final;
        if (r_mode == MODE_FULL) begin
            case (i_in_byte)
                C_QUOTE, C_BSLASH: begin
                    w_item.kind = KIND_PAIR;
                end
                C_LF: begin
                    w_item.kind   = KIND_PAIR;
                    w_item.second = C_LOW_N;
                end
                C_CR: begin
                    w_item.kind   = KIND_PAIR;
                    w_item.second = C_LOW_R;
                end
                C_TAB: begin
                    w_item.kind   = KIND_PAIR;
                    w_item.second = C_LOW_T;
                end
                C_BEL: begin
                    w_item.kind   = KIND_PAIR;
                    w_item.second = C_LOW_A;
                end
                default: begin
                    if (i_in_byte < C_PRINT_LO || i_in_byte > C_PRINT_HI) begin
                        w_item.kind = KIND_OCTAL;
                    end
                end
            endcase
        end else begin
            if (i_in_byte == C_BSLASH) begin
                w_item.kind = KIND_PAIR;
            end else if (i_in_byte == C_LF) begin
                w_item.kind   = KIND_PAIR;
                w_item.second = C_LOW_N;
            end
        end
    end

    assign o_in_stall   = i_q_status.full;
    assign o_push.valid = i_in_valid && !i_q_status.full;
    assign o_push.item  = w_item;

endmodule

### sv/cse_queue.sv
// ----------------------------------------------------------------------------
// cse_queue
// Small register queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module cse_queue import cse_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    input  logic      i_pop,
    output t_item     o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic [PTR_W-1:0]   n_wr_ptr;
    logic [PTR_W-1:0]   n_rd_ptr;
    logic [CNT_W-1:0]   n_count;
    logic               w_do_push;
    logic               w_do_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_do_push      = i_push.valid && !o_status.full;
    assign w_do_pop       = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!w_do_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push.item;
        end
    end

endmodule

### sv/cse_back.sv
// ----------------------------------------------------------------------------
// cse_back
// Steps through the run of the head item into the output register, one byte
// per cycle unless stalled, popping the item when its last byte is loaded.
// ----------------------------------------------------------------------------
module cse_back import cse_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_item      i_head,
    input  t_q_status  i_q_status,
    input  logic       i_out_stall,
    output logic       o_pop,
    output logic       o_out_valid,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_string_last
);

    logic [1:0] r_idx;
    logic [1:0] n_idx;
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_string_last;
    logic [1:0] w_last_idx;
    logic [7:0] w_byte;
    logic       w_load;
    logic       w_is_last;

    always_comb begin
        case (i_head.kind)
            KIND_PAIR:  w_last_idx = 2'd1;
            KIND_OCTAL: w_last_idx = 2'd3;
            default:    w_last_idx = 2'd0;
        endcase
    end

    always_comb begin
        w_byte = i_head.byte_val;
        case (i_head.kind)
            KIND_PAIR: begin
                w_byte = (r_idx == 2'd0) ? C_BSLASH : i_head.second;
            end
            KIND_OCTAL: begin
                case (r_idx)
                    2'd0:    w_byte = C_BSLASH;
                    2'd1:    w_byte = C_ZERO | {6'd0, i_head.byte_val[7:6]};
                    2'd2:    w_byte = C_ZERO | {5'd0, i_head.byte_val[5:3]};
                    default: w_byte = C_ZERO | {5'd0, i_head.byte_val[2:0]};
                endcase
            end
            default: begin
                w_byte = i_head.byte_val;
            end
        endcase
    end

    assign w_load    = !i_q_status.empty && (!r_valid || !i_out_stall);
    assign w_is_last = (r_idx == w_last_idx);
    assign o_pop     = w_load && w_is_last;

    always_comb begin
        n_idx   = r_idx;
        n_valid = r_valid && i_out_stall;
        if (w_load) begin
            n_valid = 1'b1;
            n_idx   = w_is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte        <= w_byte;
            r_run_last    <= w_is_last;
            r_string_last <= w_is_last && i_head.final_flag;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_run_last    = r_run_last;
    assign o_string_last = r_string_last;

endmodule

### sv/c_string_escaper_core.sv
// ----------------------------------------------------------------------------
// c_string_escaper_core
// C string literal escaper: one source byte in, a run of escaped bytes out.
// ----------------------------------------------------------------------------
// Each accepted byte yields a run of one byte (plain), two bytes (backslash
// pair) or four bytes (backslash and three octal digits), marked by run_last
// and, for the string's final byte, string_last. The output side produces one
// byte per cycle while i_out_stall is low, stepping the back-end byte sequencer
// through each item's run; input bytes are taken every cycle while the item
// queue (DEPTH entries) has room. On an empty block the first output byte
// passes the item queue and then the output register before it is presented.
// The user must write escape_mode only while idle; the block does not enforce it.
module c_string_escaper_core import cse_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_final,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_string_last
);

    t_push     w_push;
    t_item     w_head;
    t_q_status w_q_status;
    logic      w_pop;

    cse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .i_in_byte     (i_in_byte),
        .i_in_final    (i_in_final),
        .i_q_status    (w_q_status),
        .o_in_stall    (o_in_stall),
        .o_push        (w_push)
    );

    cse_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    cse_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_status    (w_q_status),
        .i_out_stall   (i_out_stall),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_string_last (o_string_last)
    );

endmodule

### sv/cse_checker.sv
// ----------------------------------------------------------------------------
// cse_checker
// Port-level checks on the escaper output stream.
// ----------------------------------------------------------------------------
module cse_checker import cse_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_string_last
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_run_last)
            && $stable(o_string_last))
        else $error("stalled output changed");

    a_string_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_string_last |-> o_run_last)
        else $error("string_last without run_last");

    a_inner_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_last |->
            (o_out_byte == C_BSLASH) || (o_out_byte >= C_ZERO && o_out_byte <= C_SEVEN))
        else $error("inner run byte is not backslash or octal digit");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind c_string_escaper_core cse_checker u_cse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_out_byte    (o_out_byte),
    .o_run_last    (o_run_last),
    .o_string_last (o_string_last)
);
